@@ design/satb_pkg.sv @@
// Package for the service and backend table: codes, sequencer states and
// the hash helper used by the bucket hash unit.
// No dependencies.
package satb_pkg;

  // Field widths fixed by the word formats.
  localparam int unsigned OpW     = 3;
  localparam int unsigned SkeyW   = 56;
  localparam int unsigned BkeyW   = 48;
  localparam int unsigned WeightW = 16;

  // Operation codes.
  localparam logic [OpW-1:0] OP_ADD_SVC  = 3'd0;
  localparam logic [OpW-1:0] OP_DEL_SVC  = 3'd1;
  localparam logic [OpW-1:0] OP_FIND_SVC = 3'd2;
  localparam logic [OpW-1:0] OP_ADD_BE   = 3'd3;
  localparam logic [OpW-1:0] OP_DEL_BE   = 3'd4;
  localparam logic [OpW-1:0] OP_FIND_BE  = 3'd5;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EXISTS   = 3'd1;
  localparam logic [2:0] ST_NO_ROOM  = 3'd2;
  localparam logic [2:0] ST_NOT_FND  = 3'd3;
  localparam logic [2:0] ST_SVC_MISS = 3'd4;

  // Hash constants: the 0xdeadbeef seed plus the three-word length.
  localparam logic [31:0] JhInit = 32'hdeadbeef + 32'd12;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_SRD,
    S_SCMP,
    S_SDEC,
    S_BRD,
    S_BCMP,
    S_BDEC,
    S_DONE
  } state_e;

  // Handshake between the sequencer and the hash unit.
  typedef struct packed {
    logic busy;
    logic done;
  } hash_stat_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned k);
    logic [63:0] dbl;
    dbl = {x, x} << k;
    return dbl[63:32];
  endfunction

endpackage

@@ design/satb_if.sv @@
// Channel interfaces for the service and backend table: the op word in,
// the result word out. Depends on nothing.
interface satb_op_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  proto;
  logic [31:0] virt_addr;
  logic [15:0] virt_port;
  logic [31:0] backend_addr;
  logic [15:0] backend_port;
  logic [15:0] backend_weight;

  modport source(output valid, op, proto, virt_addr, virt_port, backend_addr,
                 backend_port, backend_weight, input ready);
  modport sink(input valid, op, proto, virt_addr, virt_port, backend_addr,
               backend_port, backend_weight, output ready);
endinterface

interface satb_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  service_slot;
  logic [2:0]  backend_slot;
  logic [15:0] found_weight;
  logic [3:0]  backend_total;

  modport source(output valid, status, service_slot, backend_slot, found_weight,
                 backend_total, input ready);
  modport sink(input valid, status, service_slot, backend_slot, found_weight,
               backend_total, output ready);
endinterface

@@ design/service_and_backend_table_unit.sv @@
// Top level of the service and backend table: sequencer, service record
// memory and backend memory. Uses satb_pkg, satb_if and satb_hash.
//
//   channel | dir | carries
//   --------+-----+------------------------------------------------------------
//   op_i    | in  | op, service key, backend key and weight, one word per op
//   res_o   | out | status, service slot, backend slot, weight, backend count
//
// One op word is worked on at a time. It is accepted, then the bucket hash
// runs (7 mix rounds, the remainder by reciprocal multiplication, then the
// hand-over); each bucket way walked is read and then compared, a decision
// follows, and backend ops then read and compare each backend slot in turn
// and decide again, before the result register is loaded. The walks through
// the two memories grow with BUCKET_WAYS and MAX_BACKENDS.
// Reset clears the service valid flags and the sequencer; memory contents are
// only read under a valid flag or a backend mask bit, so no clearing pass runs.
// A result waiting on res_o does not stop the next op word being accepted;
// only the hand-over into the result register waits for it to be taken.
module service_and_backend_table_unit import satb_pkg::*; #(
  parameter int unsigned NUM_BUCKETS  = 64,
  parameter int unsigned BUCKET_WAYS  = 4,
  parameter int unsigned MAX_BACKENDS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  satb_op_if.sink     op_i,
  satb_res_if.source  res_o
);

  localparam int unsigned NumSvc = NUM_BUCKETS * BUCKET_WAYS;
  localparam int unsigned SlotW  = (NumSvc > 1) ? $clog2(NumSvc) : 1;
  localparam int unsigned BkW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned WayW   = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int unsigned BidxW  = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
  localparam int unsigned CntW   = $clog2(MAX_BACKENDS + 1);
  // Service record: key, backend count, backend occupancy mask.
  localparam int unsigned RecW   = SkeyW + CntW + MAX_BACKENDS;
  localparam int unsigned BeAw   = SlotW + BidxW;
  localparam int unsigned BeW    = BkeyW + WeightW;
  localparam logic [WayW-1:0]  LastWay = WayW'(BUCKET_WAYS - 1);
  localparam logic [BidxW-1:0] LastBe  = BidxW'(MAX_BACKENDS - 1);
  localparam logic [CntW-1:0]  MaxCnt  = CntW'(MAX_BACKENDS);

  // Memories: records are live only under svc_valid_q, backend words only
  // under their bit in the record's mask.
  logic [RecW-1:0] svc_mem [NumSvc];
  logic [BeW-1:0]  be_mem  [2**BeAw];
  logic [RecW-1:0] svc_rdata_q;
  logic [BeW-1:0]  be_rdata_q;
  logic [NumSvc-1:0] svc_valid_q;

  state_e state_q, state_d;
  logic [OpW-1:0]     op_q, op_d;
  logic [SkeyW-1:0]   skey_q, skey_d;
  logic [BkeyW-1:0]   bkey_q, bkey_d;
  logic [WeightW-1:0] wt_q, wt_d, bw_q, bw_d, fw_q, fw_d;
  logic [SlotW-1:0]   base_q, base_d, cur_q, cur_d, sslot_q, sslot_d;
  logic [WayW-1:0]    way_q, way_d;
  logic [RecW-1:0]    rec_q, rec_d;
  logic [BidxW-1:0]   bidx_q, bidx_d, bslot_q, bslot_d;
  logic               hit_q, hit_d, bhit_q, bhit_d;
  logic [2:0]         status_q, status_d;
  logic [CntW-1:0]    total_q, total_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_status_q;
  logic [7:0]  out_sslot_q;
  logic [2:0]  out_bslot_q;
  logic [15:0] out_fw_q;
  logic [3:0]  out_total_q;
  logic        out_load;

  logic             svc_we, be_we, vld_we, vld_val;
  logic [SlotW-1:0] svc_raddr, svc_waddr, vld_idx;
  logic [RecW-1:0]  svc_wdata;
  logic [BeAw-1:0]  be_raddr, be_waddr;
  logic [BeW-1:0]   be_wdata;

  logic             hash_start;
  hash_stat_t       hash_stat;
  logic [BkW-1:0]   bucket;

  logic             free_way;
  logic [SlotW-1:0] free_slot;
  logic             free_be;
  logic [BidxW-1:0] free_idx;
  logic [CntW-1:0]  rec_cnt;
  logic [MAX_BACKENDS-1:0] rec_mask;
  logic             accept;

  satb_hash #(.NUM_BUCKETS(NUM_BUCKETS)) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .proto_i  (op_i.proto),
    .addr_i   (op_i.virt_addr),
    .port_i   (op_i.virt_port),
    .stat_o   (hash_stat),
    .bucket_o (bucket)
  );

  assign accept   = op_i.valid && op_i.ready;
  assign rec_cnt  = rec_q[MAX_BACKENDS +: CntW];
  assign rec_mask = rec_q[MAX_BACKENDS-1:0];

  // Lowest free way of the bucket, straight from the valid flags.
  always_comb begin
    free_way  = 1'b0;
    free_slot = '0;
    for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
      if (!svc_valid_q[SlotW'(base_q + SlotW'(w))]) begin
        free_way  = 1'b1;
        free_slot = SlotW'(base_q + SlotW'(w));
      end
    end
  end

  // Lowest free backend slot of the service record held.
  always_comb begin
    free_be  = 1'b0;
    free_idx = '0;
    for (int i = MAX_BACKENDS - 1; i >= 0; i--) begin
      if (!rec_mask[i]) begin
        free_be  = 1'b1;
        free_idx = BidxW'(i);
      end
    end
  end

  always_comb begin
    logic [MAX_BACKENDS-1:0] new_mask;
    logic [CntW-1:0]         new_cnt;
    state_d  = state_q;
    op_d     = op_q;
    skey_d   = skey_q;
    bkey_d   = bkey_q;
    wt_d     = wt_q;
    bw_d     = bw_q;
    fw_d     = fw_q;
    base_d   = base_q;
    cur_d    = cur_q;
    sslot_d  = sslot_q;
    way_d    = way_q;
    rec_d    = rec_q;
    bidx_d   = bidx_q;
    bslot_d  = bslot_q;
    hit_d    = hit_q;
    bhit_d   = bhit_q;
    status_d = status_q;
    total_d  = total_q;
    hash_start = 1'b0;
    svc_we    = 1'b0;
    svc_waddr = sslot_q;
    svc_wdata = rec_q;
    be_we     = 1'b0;
    be_waddr  = {sslot_q, free_idx};
    be_wdata  = {bkey_q, wt_q};
    vld_we    = 1'b0;
    vld_val   = 1'b0;
    vld_idx   = sslot_q;
    out_load  = 1'b0;
    new_mask  = rec_mask;
    new_cnt   = rec_cnt;
    svc_raddr = SlotW'(base_q + SlotW'(way_q));
    be_raddr  = {sslot_q, bidx_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = op_i.op;
          skey_d   = {op_i.proto, op_i.virt_addr, op_i.virt_port};
          bkey_d   = {op_i.backend_addr, op_i.backend_port};
          wt_d     = op_i.backend_weight;
          status_d = ST_NOT_FND;
          sslot_d  = '0;
          bslot_d  = '0;
          fw_d     = '0;
          total_d  = '0;
          hit_d    = 1'b0;
          bhit_d   = 1'b0;
          if (op_i.op > OP_FIND_BE) begin
            state_d = S_DONE;
          end else begin
            hash_start = 1'b1;
            state_d    = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_stat.done) begin
          base_d  = SlotW'(bucket * BUCKET_WAYS);
          way_d   = '0;
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        cur_d   = svc_raddr;
        state_d = S_SCMP;
      end
      S_SCMP: begin
        if (svc_valid_q[cur_q] && svc_rdata_q[RecW-1 -: SkeyW] == skey_q) begin
          hit_d   = 1'b1;
          sslot_d = cur_q;
          rec_d   = svc_rdata_q;
          state_d = S_SDEC;
        end else if (way_q == LastWay) begin
          state_d = S_SDEC;
        end else begin
          way_d   = way_q + WayW'(1);
          state_d = S_SRD;
        end
      end
      S_SDEC: begin
        state_d = S_DONE;
        unique case (op_q)
          OP_ADD_SVC: begin
            if (hit_q) begin
              status_d = ST_EXISTS;
              total_d  = rec_cnt;
            end else if (free_way) begin
              // A new service starts with an empty backend list.
              svc_we    = 1'b1;
              svc_waddr = free_slot;
              svc_wdata = {skey_q, {CntW{1'b0}}, {MAX_BACKENDS{1'b0}}};
              vld_we    = 1'b1;
              vld_val   = 1'b1;
              vld_idx   = free_slot;
              status_d  = ST_OK;
              sslot_d   = free_slot;
            end else begin
              status_d = ST_NO_ROOM;
            end
          end
          OP_DEL_SVC: begin
            if (hit_q) begin
              vld_we   = 1'b1;
              status_d = ST_OK;
            end
          end
          OP_FIND_SVC: begin
            if (hit_q) begin
              status_d = ST_OK;
              total_d  = rec_cnt;
            end
          end
          default: begin
            if (!hit_q) begin
              status_d = ST_SVC_MISS;
            end else begin
              bidx_d  = '0;
              state_d = S_BRD;
            end
          end
        endcase
      end
      S_BRD: begin
        state_d = S_BCMP;
      end
      S_BCMP: begin
        if (rec_mask[bidx_q] && !bhit_q && be_rdata_q[BeW-1 -: BkeyW] == bkey_q) begin
          bhit_d  = 1'b1;
          bslot_d = bidx_q;
          bw_d    = be_rdata_q[WeightW-1:0];
        end
        if (bidx_q == LastBe) begin
          state_d = S_BDEC;
        end else begin
          bidx_d  = bidx_q + BidxW'(1);
          state_d = S_BRD;
        end
      end
      S_BDEC: begin
        state_d = S_DONE;
        total_d = rec_cnt;
        unique case (op_q)
          OP_ADD_BE: begin
            if (bhit_q) begin
              status_d = ST_EXISTS;
            end else if (free_be) begin
              new_mask = rec_mask | (MAX_BACKENDS'(1) << free_idx);
              new_cnt  = rec_cnt + CntW'(1);
              be_we    = 1'b1;
              svc_we   = 1'b1;
              svc_wdata = {rec_q[RecW-1 -: SkeyW], new_cnt, new_mask};
              status_d = ST_OK;
              bslot_d  = free_idx;
              total_d  = new_cnt;
            end else begin
              status_d = ST_NO_ROOM;
            end
          end
          OP_DEL_BE: begin
            if (bhit_q) begin
              new_mask = rec_mask & ~(MAX_BACKENDS'(1) << bslot_q);
              if (rec_cnt != '0) new_cnt = rec_cnt - CntW'(1);
              svc_we    = 1'b1;
              svc_wdata = {rec_q[RecW-1 -: SkeyW], new_cnt, new_mask};
              status_d  = ST_OK;
              total_d   = new_cnt;
            end else begin
              status_d = ST_NOT_FND;
            end
          end
          default: begin
            if (bhit_q) begin
              status_d = ST_OK;
              fw_d     = bw_q;
            end else begin
              status_d = ST_NOT_FND;
            end
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) out_valid_d = 1'b0;
    if (out_load)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      svc_valid_q <= '0;
      hit_q       <= 1'b0;
      bhit_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      bhit_q      <= bhit_d;
      if (vld_we) svc_valid_q[vld_idx] <= vld_val;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    skey_q   <= skey_d;
    bkey_q   <= bkey_d;
    wt_q     <= wt_d;
    bw_q     <= bw_d;
    fw_q     <= fw_d;
    base_q   <= base_d;
    cur_q    <= cur_d;
    sslot_q  <= sslot_d;
    way_q    <= way_d;
    rec_q    <= rec_d;
    bidx_q   <= bidx_d;
    bslot_q  <= bslot_d;
    status_q <= status_d;
    total_q  <= total_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_sslot_q  <= 8'(sslot_q);
      out_bslot_q  <= 3'(bslot_q);
      out_fw_q     <= fw_q;
      out_total_q  <= 4'(total_q);
    end
  end

  // Service record memory: one read and one write port.
  always_ff @(posedge clk_i) begin
    if (svc_we) svc_mem[svc_waddr] <= svc_wdata;
    svc_rdata_q <= svc_mem[svc_raddr];
  end

  // Backend memory: slot address is the service slot and the list index.
  always_ff @(posedge clk_i) begin
    if (be_we) be_mem[be_waddr] <= be_wdata;
    be_rdata_q <= be_mem[be_raddr];
  end

  assign op_i.ready          = (state_q == S_IDLE);
  assign res_o.valid         = out_valid_q;
  assign res_o.status        = out_status_q;
  assign res_o.service_slot  = out_sslot_q;
  assign res_o.backend_slot  = out_bslot_q;
  assign res_o.found_weight  = out_fw_q;
  assign res_o.backend_total = out_total_q;

  // The hash unit is only started from idle on an accepted word.
  a_hash_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_start |-> (state_q == S_IDLE && accept))
    else $error("hash started outside an accepted op");

  // A new service is only placed in a way that was free.
  a_alloc_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_we && vld_val) |-> !svc_valid_q[vld_idx])
    else $error("service allocated over a live way");

  // A record written back never holds more backends than the list allows.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    svc_we |-> (svc_wdata[MAX_BACKENDS +: CntW] <= MaxCnt))
    else $error("backend count beyond list size");

  // A result is handed over only from the done state, and the sequencer idles next.
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q == S_IDLE && out_valid_q))
    else $error("result load out of sequence");

endmodule

@@ design/satb_hash.sv @@
// Bucket hash unit: the three-word final mix, one round a cycle, then the
// remainder modulo the bucket count by reciprocal multiplication.
// Uses satb_pkg.
module satb_hash import satb_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [7:0]          proto_i,
  input  logic [31:0]         addr_i,
  input  logic [15:0]         port_i,
  output hash_stat_t          stat_o,
  output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] bucket_o
);

  localparam int unsigned BkW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  // Quotient is (c * Recip) >> ShR, exact for every 32-bit c.
  localparam int unsigned RecL = $clog2(NUM_BUCKETS);
  localparam int unsigned ShR  = 32 + RecL;
  localparam logic [63:0] Recip = ((64'd1 << ShR) + 64'(NUM_BUCKETS) - 64'd1) /
                                  64'(NUM_BUCKETS);
  localparam logic [31:0] RecipLo = Recip[31:0];
  localparam logic        RecipHi = Recip[32];
  localparam logic [31:0] NbW     = 32'(NUM_BUCKETS);
  localparam logic [3:0] LastMix = 4'd6;
  localparam logic [3:0] MulCnt  = 4'd7;
  localparam logic [3:0] QnCnt   = 4'd8;

  logic        busy_q, busy_d, done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] a_q, b_q, c_q, a_d, b_d, c_d;
  logic [64:0] prod_q, prod_d;
  logic [31:0] qn_q, qn_d;
  logic [BkW-1:0] rem_q, rem_d;

  always_comb begin
    logic [63:0] lo_prod;
    logic [31:0] quo;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    prod_d = prod_q;
    qn_d = qn_q;
    rem_d = rem_q;
    lo_prod = {32'd0, c_q} * {32'd0, RecipLo};
    quo = 32'(prod_q >> ShR);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d = {24'd0, proto_i} + JhInit + {16'd0, port_i};
      b_d = addr_i + JhInit + {16'd0, port_i};
      c_d = JhInit + {16'd0, port_i};
      rem_d = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 4'd1;
      if (cnt_q <= LastMix) begin
        unique case (cnt_q)
          4'd0:    c_d = (c_q ^ b_q) - rotl32(b_q, 14);
          4'd1:    a_d = (a_q ^ c_q) - rotl32(c_q, 11);
          4'd2:    b_d = (b_q ^ a_q) - rotl32(a_q, 25);
          4'd3:    c_d = (c_q ^ b_q) - rotl32(b_q, 16);
          4'd4:    a_d = (a_q ^ c_q) - rotl32(c_q, 4);
          4'd5:    b_d = (b_q ^ a_q) - rotl32(a_q, 14);
          default: c_d = (c_q ^ b_q) - rotl32(b_q, 24);
        endcase
      end else begin
        unique case (cnt_q)
          MulCnt: prod_d = {1'b0, lo_prod} + (RecipHi ? {1'b0, c_q, 32'd0} : 65'd0);
          QnCnt:  qn_d = quo * NbW;
          default: begin
            rem_d  = BkW'(c_q - qn_q);
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    prod_q <= prod_d;
    qn_q <= qn_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign bucket_o    = rem_q;

endmodule
